/* rtl/core/rspd_pkg.sv */
package rspd_pkg;

  localparam int unsigned LenWidth = 12;
  localparam logic [LenWidth-1:0] MaxPayloadLenReset = 12'd2047;

  localparam logic [2:0] PH_HUNT    = 3'd0;
  localparam logic [2:0] PH_PAYLOAD = 3'd1;
  localparam logic [2:0] PH_SKIP    = 3'd2;
  localparam logic [2:0] PH_CK_HI   = 3'd3;
  localparam logic [2:0] PH_CK_LO   = 3'd4;

  localparam logic [2:0] K_BYTE     = 3'd0;
  localparam logic [2:0] K_RESTART  = 3'd1;
  localparam logic [2:0] K_ACCEPT   = 3'd2;
  localparam logic [2:0] K_MISMATCH = 3'd3;
  localparam logic [2:0] K_BADHEX   = 3'd4;
  localparam logic [2:0] K_OVERFLOW = 3'd5;

  localparam logic [7:0] CH_START = 8'h24;
  localparam logic [7:0] CH_END   = 8'h23;
  localparam logic [7:0] CH_ACK   = 8'h2b;
  localparam logic [7:0] CH_NAK   = 8'h2d;

  typedef struct packed {
    logic [2:0]          phase;
    logic [7:0]          running_sum;
    logic [LenWidth-1:0] payload_count;
    logic [3:0]          high_nibble;
  } state_t;

  typedef struct packed {
    logic [2:0]          kind;
    logic [7:0]          payload_byte;
    logic                send_ack;
    logic [7:0]          ack_byte;
    logic [LenWidth-1:0] packet_length;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    logic [7:0] d;
    h = '0;
    d = '0;
    if (c inside {[8'h30:8'h39]}) begin
      d = c - 8'h30;
      h.ok = 1'b1;
    end else if (c inside {[8'h61:8'h66]}) begin
      d = c - 8'h57;
      h.ok = 1'b1;
    end else if (c inside {[8'h41:8'h46]}) begin
      d = c - 8'h37;
      h.ok = 1'b1;
    end
    h.value = d[3:0];
    return h;
  endfunction

endpackage

/* rtl/core/rsp_packet_deframer_core.sv */
// Channel   Direction  Handshake             Payload
// input     in         in_valid/in_ready     rx_byte
// output    out        out_valid/out_ready   kind, payload_byte, send_ack, ack_byte,
//                                            packet_length
// config    in         cfg_wr_en             cfg_wr_data (max_payload_len)
//
// One byte per cycle sustained while the output is not stalled; an accepted byte is
// registered in the input register first, then its result in the output register.
// Bytes that cause no result update the parser state and leave no output.
// Synchronous reset clears the parser state, both valids and sets the limit to 2047.
// A stalled output holds the input register; in_ready drops only when both are full.
module rsp_packet_deframer_core
  import rspd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          rx_byte,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          kind,
  output logic [7:0]          payload_byte,
  output logic                send_ack,
  output logic [7:0]          ack_byte,
  output logic [LenWidth-1:0] packet_length,
  input  logic                cfg_wr_en,
  input  logic [LenWidth-1:0] cfg_wr_data
);

  logic [LenWidth-1:0] max_payload_len;
  logic                byte_valid;
  logic [7:0]          byte_q;
  state_t              state;
  state_t              state_next;
  logic                emit;
  result_t             result;
  result_t             result_q;
  logic                advance;

  assign advance  = byte_valid && (!out_valid || out_ready);
  assign in_ready = !byte_valid || advance;

  rspd_step u_step (
    .state           (state),
    .rx_byte         (byte_q),
    .max_payload_len (max_payload_len),
    .state_next      (state_next),
    .emit            (emit),
    .result          (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload_len <= MaxPayloadLenReset;
    end else if (cfg_wr_en) begin
      max_payload_len <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (in_ready) begin
      byte_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_q <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{phase: PH_HUNT, running_sum: '0, payload_count: '0, high_nibble: '0};
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      result_q <= result;
    end
  end

  assign kind          = result_q.kind;
  assign payload_byte  = result_q.payload_byte;
  assign send_ack      = result_q.send_ack;
  assign ack_byte      = result_q.ack_byte;
  assign packet_length = result_q.packet_length;

endmodule

/* rtl/core/rspd_step.sv */
module rspd_step
  import rspd_pkg::*;
(
  input  state_t              state,
  input  logic [7:0]          rx_byte,
  input  logic [LenWidth-1:0] max_payload_len,
  output state_t              state_next,
  output logic                emit,
  output result_t             result
);

  hex_t hex;

  assign hex = hex_decode(rx_byte);

  always_comb begin
    state_next = state;
    emit = 1'b0;
    result = '0;
    case (state.phase)
      PH_PAYLOAD: begin
        if (rx_byte == CH_END) begin
          state_next.phase = PH_CK_HI;
        end else if (rx_byte == CH_START) begin
          state_next.running_sum = '0;
          state_next.payload_count = '0;
          emit = 1'b1;
          result.kind = K_RESTART;
        end else if (state.payload_count >= max_payload_len) begin
          state_next.payload_count = '0;
          state_next.running_sum = 8'd1;
          state_next.phase = PH_SKIP;
          emit = 1'b1;
          result.kind = K_OVERFLOW;
        end else begin
          state_next.payload_count = state.payload_count + 1'b1;
          state_next.running_sum = state.running_sum + rx_byte;
          emit = 1'b1;
          result.kind = K_BYTE;
          result.payload_byte = rx_byte;
        end
      end
      PH_SKIP: begin
        if (rx_byte == CH_END) begin
          state_next.phase = PH_CK_HI;
        end
      end
      PH_CK_HI: begin
        if (!hex.ok) begin
          state_next.phase = PH_HUNT;
          emit = 1'b1;
          result.kind = K_BADHEX;
        end else begin
          state_next.high_nibble = hex.value;
          state_next.phase = PH_CK_LO;
        end
      end
      PH_CK_LO: begin
        state_next.phase = PH_HUNT;
        emit = 1'b1;
        if (!hex.ok) begin
          result.kind = K_BADHEX;
        end else if ({state.high_nibble, hex.value} != state.running_sum) begin
          result.kind = K_MISMATCH;
          result.send_ack = 1'b1;
          result.ack_byte = CH_NAK;
        end else begin
          result.kind = K_ACCEPT;
          result.send_ack = 1'b1;
          result.ack_byte = CH_ACK;
          result.packet_length = state.payload_count;
        end
      end
      default: begin
        if (rx_byte == CH_START) begin
          state_next.running_sum = '0;
          state_next.payload_count = '0;
          state_next.phase = PH_PAYLOAD;
        end else begin
          state_next.phase = PH_HUNT;
        end
      end
    endcase
  end

endmodule
